@@ rtl/lph_pkg.sv @@
// ----------------------------------------------------------------------------
// lph_pkg
// shared types and constants of the linear-probing hash insert block
// ----------------------------------------------------------------------------
package lph_pkg;

   localparam int TABLE_SIZE   = 256;
   localparam int KEY_BITS     = 16;
   localparam int SLOT_BITS    = $clog2(TABLE_SIZE);
   localparam int CFG_BITS     = 9;
   localparam int PROBE_BITS   = 9;
   localparam int SUM_BITS     = 17;
   localparam int COUNT_BITS   = 9;
   localparam int MOD_CNT_BITS = $clog2(KEY_BITS);

   localparam logic [SUM_BITS-1:0]   SUM_MAX   = '1;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [CFG_BITS-1:0]   LEN_MAX   = CFG_BITS'(TABLE_SIZE);

   localparam logic CSR_DIVISOR      = 1'b0;
   localparam logic CSR_TABLE_LENGTH = 1'b1;

   typedef enum logic [1:0] {
      ST_INSERTED = 2'd0,
      ST_FULL     = 2'd1,
      ST_ZERO_KEY = 2'd2,
      ST_READ     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CMD_INSERT,
      CMD_ZERO,
      CMD_READ
   } cmd_kind_type;

   typedef struct packed {
      logic                 action;
      logic [KEY_BITS-1:0]  key;
      logic [SLOT_BITS-1:0] slot_index;
   } req_type;

   typedef struct packed {
      status_type            status;
      logic [SLOT_BITS-1:0]  slot;
      logic [PROBE_BITS-1:0] probes;
      logic [SUM_BITS-1:0]   total_probes;
      logic [COUNT_BITS-1:0] inserted_count;
      logic [KEY_BITS-1:0]   read_key;
   } rsp_type;

   typedef struct packed {
      cmd_kind_type         kind;
      logic [KEY_BITS-1:0]  key;
      logic [SLOT_BITS-1:0] slot_index;
   } cmd_type;

   typedef struct packed {
      logic [CFG_BITS-1:0] divisor;
      logic [CFG_BITS-1:0] table_length;
   } csr_type;

endpackage

@@ rtl/lph_ram.sv @@
// ----------------------------------------------------------------------------
// lph_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module lph_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/lph_front.sv @@
// ----------------------------------------------------------------------------
// lph_front
// accepts request items, classifies them and holds them in a two-entry queue
// ----------------------------------------------------------------------------
module lph_front
   import lph_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    cmd_valid,
   input  logic    cmd_pop,
   output cmd_type cmd
);

   cmd_type     q_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push_ok;
   logic        pop_ok;
   cmd_type     cmd_new;

   always_comb begin
      cmd_new.key        = req_data.key;
      cmd_new.slot_index = req_data.slot_index;
      if (req_data.action) begin
         cmd_new.kind = CMD_READ;
      end else if (req_data.key == '0) begin
         cmd_new.kind = CMD_ZERO;
      end else begin
         cmd_new.kind = CMD_INSERT;
      end
   end

   assign req_full  = (count_ff == 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = push_ok ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_ok ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push_ok) - 2'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push_ok) begin
         q_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

@@ rtl/lph_mod.sv @@
// ----------------------------------------------------------------------------
// lph_mod
// bit-serial restoring remainder unit, one key bit per cycle
// ----------------------------------------------------------------------------
module lph_mod
   import lph_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [KEY_BITS-1:0] dividend,
   input  logic [CFG_BITS-1:0] divisor,
   output logic                done,
   output logic [CFG_BITS-1:0] remainder
);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [MOD_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [KEY_BITS-1:0]     key_ff, key_in;
   logic [CFG_BITS-1:0]     rem_ff, rem_in;
   logic [CFG_BITS:0]       trial;

   assign trial = {rem_ff, key_ff[KEY_BITS-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      key_in  = key_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = MOD_CNT_BITS'(KEY_BITS - 1);
         key_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         key_in = {key_ff[KEY_BITS-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            rem_in = CFG_BITS'(trial - {1'b0, divisor});
         end else begin
            rem_in = CFG_BITS'(trial);
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      key_ff <= key_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

@@ rtl/lph_back.sv @@
// ----------------------------------------------------------------------------
// lph_back
// carries out queued items: hash, probe walk, table update, slot read, result register
// ----------------------------------------------------------------------------
module lph_back
   import lph_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  csr_type csr,
   input  logic    cmd_valid,
   output logic    cmd_pop,
   input  cmd_type cmd,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ_WAIT,
      S_HASH,
      S_PROBE,
      S_EMIT
   } state_type;

   state_type               state_ff, state_in;
   rsp_type                 res_ff, res_in;
   rsp_type                 rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [KEY_BITS-1:0]     key_ff, key_in;
   logic [SLOT_BITS-1:0]    pos_ff, pos_in;
   logic [PROBE_BITS-1:0]   probes_ff, probes_in;
   logic                    rd_valid_ff, rd_valid_in;
   logic [SUM_BITS-1:0]     probe_sum_ff, probe_sum_in;
   logic [COUNT_BITS-1:0]   stored_count_ff, stored_count_in;
   logic [TABLE_SIZE-1:0]   valid_ff, valid_in;

   logic                    mod_start;
   logic                    mod_done;
   logic [CFG_BITS-1:0]     mod_rem;
   logic [CFG_BITS-1:0]     div_eff;
   logic [CFG_BITS-1:0]     len;
   logic [CFG_BITS-1:0]     pos_next;
   logic [SUM_BITS:0]       sum_wide;
   logic                    ram_we;
   logic [KEY_BITS-1:0]     ram_rd_data;
   logic                    out_free;

   assign div_eff  = (csr.divisor == '0) ? CFG_BITS'(1) : csr.divisor;
   assign len      = (csr.table_length > LEN_MAX) ? LEN_MAX : csr.table_length;
   assign pos_next = CFG_BITS'(pos_ff) + 1'b1;
   assign sum_wide = {1'b0, probe_sum_ff} + (SUM_BITS + 1)'(probes_ff);
   assign out_free = !rsp_valid_ff || rsp_pop;

   lph_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (cmd.key),
      .divisor   (div_eff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   lph_ram #(
      .WIDTH (KEY_BITS),
      .DEPTH (TABLE_SIZE)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (pos_ff),
      .wr_data (key_ff),
      .rd_addr (cmd.slot_index),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in        = state_ff;
      res_in          = res_ff;
      rsp_in          = rsp_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_pop;
      key_in          = key_ff;
      pos_in          = pos_ff;
      probes_in       = probes_ff;
      rd_valid_in     = rd_valid_ff;
      probe_sum_in    = probe_sum_ff;
      stored_count_in = stored_count_ff;
      valid_in        = valid_ff;
      cmd_pop         = 1'b0;
      mod_start       = 1'b0;
      ram_we          = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop                = 1'b1;
               key_in                 = cmd.key;
               res_in.slot            = '0;
               res_in.probes          = '0;
               res_in.total_probes    = probe_sum_ff;
               res_in.inserted_count  = stored_count_ff;
               res_in.read_key        = '0;
               unique case (cmd.kind)
                  CMD_READ: begin
                     res_in.status = ST_READ;
                     res_in.slot   = cmd.slot_index;
                     rd_valid_in   = valid_ff[cmd.slot_index];
                     state_in      = S_READ_WAIT;
                  end
                  CMD_ZERO: begin
                     res_in.status = ST_ZERO_KEY;
                     state_in      = S_EMIT;
                  end
                  CMD_INSERT: begin
                     mod_start = 1'b1;
                     state_in  = S_HASH;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_READ_WAIT: begin
            res_in.read_key = rd_valid_ff ? ram_rd_data : '0;
            state_in        = S_EMIT;
         end
         S_HASH: begin
            if (mod_done) begin
               pos_in    = (mod_rem >= len) ? '0 : SLOT_BITS'(mod_rem);
               probes_in = PROBE_BITS'(1);
               if (len == '0) begin
                  res_in.status = ST_FULL;
                  state_in      = S_EMIT;
               end else begin
                  state_in = S_PROBE;
               end
            end
         end
         S_PROBE: begin
            if (!valid_ff[pos_ff]) begin
               ram_we           = 1'b1;
               valid_in[pos_ff] = 1'b1;
               probe_sum_in     = (sum_wide > {1'b0, SUM_MAX}) ? SUM_MAX
                                                               : SUM_BITS'(sum_wide);
               stored_count_in  = (stored_count_ff == COUNT_MAX) ? COUNT_MAX
                                                                 : stored_count_ff + 1'b1;
               res_in.status         = ST_INSERTED;
               res_in.slot           = pos_ff;
               res_in.probes         = probes_ff;
               res_in.total_probes   = probe_sum_in;
               res_in.inserted_count = stored_count_in;
               state_in              = S_EMIT;
            end else if (probes_ff == PROBE_BITS'(len)) begin
               res_in.status = ST_FULL;
               res_in.probes = probes_ff;
               state_in      = S_EMIT;
            end else begin
               probes_in = probes_ff + 1'b1;
               pos_in    = (pos_next >= len) ? '0 : SLOT_BITS'(pos_next);
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         rsp_valid_ff    <= 1'b0;
         probe_sum_ff    <= '0;
         stored_count_ff <= '0;
         valid_ff        <= '0;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         probe_sum_ff    <= probe_sum_in;
         stored_count_ff <= stored_count_in;
         valid_ff        <= valid_in;
      end
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
      key_ff      <= key_in;
      pos_ff      <= pos_in;
      probes_ff   <= probes_in;
      rd_valid_ff <= rd_valid_in;
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ rtl/linear_probe_hash_insert.sv @@
// ----------------------------------------------------------------------------
// linear_probe_hash_insert
// open-addressing hash table insert with division hash and linear probing
// ----------------------------------------------------------------------------
// request side: queue-like, an item is taken when req_push is high and
// req_full is low; a two-entry queue holds items ahead of the engine
// result side: rsp_data holds the oldest result while rsp_empty is low, it
// is taken when rsp_pop is high
// configuration: csr_index 0 divisor, 1 table_length; csr_ready is always
// high, write only while the block is idle
// processing: an insert forms the key remainder one key bit per cycle and
// the probe walk visits one slot per cycle; items are carried out one at a
// time in arrival order, so the engine takes a new item only once it is
// through with the last one and has moved its result to the result register
// reset clears the table occupancy, the probe total, the insert count and
// sets both registers to 256; a stalled result side holds the result and the
// engine waits once it has the next result ready, while the request queue
// keeps filling until full
// ----------------------------------------------------------------------------
module linear_probe_hash_insert
   import lph_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  req_type             req_data,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output rsp_type             rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_index,
   input  logic [CFG_BITS-1:0] csr_data
);

   csr_type csr_ff, csr_in;
   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd;

   assign csr_ready = 1'b1;

   always_comb begin
      csr_in = csr_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_DIVISOR:      csr_in.divisor      = csr_data;
            CSR_TABLE_LENGTH: csr_in.table_length = csr_data;
            default:          csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.divisor      <= LEN_MAX;
         csr_ff.table_length <= LEN_MAX;
      end else begin
         csr_ff <= csr_in;
      end
   end

   lph_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd)
   );

   lph_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr_ff),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

@@ sim/linear_probe_hash_insert_tb.sv @@
// ----------------------------------------------------------------------------
// linear_probe_hash_insert_tb
// self-checking bench for the linear-probing hash insert block: a shadow table
// predicts every reply from the accepted item and the register values, and
// each popped reply is compared field by field; directed corner cases come
// first, then random phases that fill the table under different register
// settings with random idling on both sides
// ----------------------------------------------------------------------------
module linear_probe_hash_insert_tb;
   import lph_pkg::*;

   localparam logic        ACT_INSERT  = 1'b0;
   localparam logic        ACT_READ    = 1'b1;
   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int unsigned SETTLE      = 8;
   localparam int unsigned PHASE_ITEMS = 105;

   logic                clock;
   logic                reset     = 1'b1;
   logic                req_push  = 1'b0;
   logic                req_full;
   req_type             req_data  = '0;
   logic                rsp_empty;
   logic                rsp_pop   = 1'b0;
   rsp_type             rsp_data;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic                csr_index = CSR_DIVISOR;
   logic [CFG_BITS-1:0] csr_data  = '0;

   logic [KEY_BITS-1:0] shadow_keys [TABLE_SIZE];
   int unsigned         probe_total    = 0;
   int unsigned         key_count      = 0;
   int unsigned         hash_div       = 256;
   int unsigned         table_len      = 256;
   rsp_type             owed_replies [$];
   int unsigned         send_idle_pct  = 0;
   int unsigned         recv_stall_pct = 0;
   int unsigned         cycle_count    = 0;
   bit                  failed         = 1'b0;

   linear_probe_hash_insert dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[linear_probe_hash_insert] ERROR");
         $finish;
      end
   end

   function automatic rsp_type probe_table(input req_type item);
      rsp_type     reply;
      int unsigned span;
      int unsigned home;
      int unsigned pos;
      int unsigned n;
      bit          placed;
      reply  = '0;
      placed = 1'b0;
      if (item.action == ACT_READ) begin
         reply.status   = ST_READ;
         reply.slot     = item.slot_index;
         reply.read_key = shadow_keys[item.slot_index];
      end else if (item.key == '0) begin
         reply.status = ST_ZERO_KEY;
      end else begin
         span = (table_len > TABLE_SIZE) ? TABLE_SIZE : table_len;
         home = item.key % ((hash_div == 0) ? 1 : hash_div);
         pos  = (home >= span) ? 0 : home;
         reply.status = ST_FULL;
         reply.probes = PROBE_BITS'(span);
         n = 1;
         while (!placed && n <= span) begin
            if (shadow_keys[pos] == '0) begin
               shadow_keys[pos] = item.key;
               probe_total = (probe_total + n > SUM_MAX) ? SUM_MAX : probe_total + n;
               if (key_count < COUNT_MAX) key_count++;
               reply.status = ST_INSERTED;
               reply.slot   = SLOT_BITS'(pos);
               reply.probes = PROBE_BITS'(n);
               placed = 1'b1;
            end else begin
               pos = (pos + 1 >= span) ? 0 : pos + 1;
               n++;
            end
         end
      end
      reply.total_probes   = SUM_BITS'(probe_total);
      reply.inserted_count = COUNT_BITS'(key_count);
      return reply;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want, got);
      if (want !== got) begin
         $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         failed = 1'b1;
      end
   endtask

   task automatic compare_reply(input rsp_type got);
      rsp_type want;
      if (owed_replies.size() == 0) begin
         $display("%0t unexpected reply: expected none, actual %h", $time, got);
         failed = 1'b1;
      end else begin
         want = owed_replies.pop_front();
         check_field("status", want.status, got.status);
         check_field("slot", want.slot, got.slot);
         check_field("probes", want.probes, got.probes);
         check_field("total_probes", want.total_probes, got.total_probes);
         check_field("inserted_count", want.inserted_count, got.inserted_count);
         check_field("read_key", want.read_key, got.read_key);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) compare_reply(rsp_data);
         rsp_pop <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic send_item(input req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_data <= item;
      req_push <= 1'b1;
      @(posedge clock);
      while (req_full) @(posedge clock);
      owed_replies.push_back(probe_table(item));
   endtask

   task automatic put_key(input logic [KEY_BITS-1:0] key);
      req_type item;
      item            = '0;
      item.action     = ACT_INSERT;
      item.key        = key;
      item.slot_index = SLOT_BITS'($urandom());
      send_item(item);
   endtask

   task automatic peek_slot(input logic [SLOT_BITS-1:0] idx);
      req_type item;
      item            = '0;
      item.action     = ACT_READ;
      item.key        = KEY_BITS'($urandom());
      item.slot_index = idx;
      send_item(item);
   endtask

   // sender holds off until every reply is back, then the block is idle
   task automatic wait_for_replies();
      req_push <= 1'b0;
      while (owed_replies.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_regs(input logic [CFG_BITS-1:0] div, len);
      csr_valid <= 1'b1;
      csr_index <= CSR_DIVISOR;
      csr_data  <= div;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      hash_div  = div;
      csr_index <= CSR_TABLE_LENGTH;
      csr_data  <= len;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      table_len = len;
      csr_valid <= 1'b0;
   endtask

   // reset registers: collisions, duplicates and wrap past the last slot
   task automatic test_directed_inserts();
      put_key(16'h0000);
      peek_slot(8'd0);
      peek_slot(8'd255);
      put_key(16'hFFFF);
      put_key(16'h0001);
      put_key(16'h0100);
      put_key(16'h0101);
      put_key(16'h0001);
      put_key(16'h01FF);
      peek_slot(8'd255);
      peek_slot(8'd4);
      wait_for_replies();
   endtask

   // zero length, zero divisor, oversize registers, home past the length
   task automatic test_register_corners();
      write_regs(9'd0, 9'd0);
      put_key(16'h1234);
      peek_slot(8'd2);
      wait_for_replies();
      write_regs(9'd0, 9'd8);
      put_key(16'h8000);
      put_key(16'h4000);
      put_key(16'h2000);
      put_key(16'h1000);
      wait_for_replies();
      write_regs(9'd300, 9'd511);
      put_key(16'd299);
      put_key(16'hFFFF);
      wait_for_replies();
      write_regs(9'd511, 9'd256);
      put_key(16'hFFFE);
      wait_for_replies();
      write_regs(9'd1, 9'd1);
      put_key(16'h00AA);
      wait_for_replies();
   endtask

   // phases of growing length fill the table until inserts find it full
   task automatic test_random_fill();
      logic [CFG_BITS-1:0] divs [6];
      logic [CFG_BITS-1:0] lens [6];
      req_type             item;
      int unsigned         pick;
      divs = '{9'd13, 9'd1, 9'd0, 9'd97, 9'd256, 9'd511};
      lens = '{9'd16, 9'd48, 9'd96, 9'd160, 9'd256, 9'd511};
      divs[2] = CFG_BITS'($urandom_range(511, 2));
      for (int ph = 0; ph < 6; ph++) begin
         write_regs(divs[ph], lens[ph]);
         case (ph % 4)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 75;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 75;
            end
            default: begin
               send_idle_pct  = 26;
               recv_stall_pct = 26;
            end
         endcase
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            pick            = $urandom_range(99);
            item.action     = (pick < 20) ? ACT_READ : ACT_INSERT;
            item.key        = (pick >= 20 && pick < 25) ? '0 : KEY_BITS'($urandom());
            item.slot_index = SLOT_BITS'($urandom());
            send_item(item);
            if (i == PHASE_ITEMS / 2 && ph == 3) wait_for_replies();
         end
         wait_for_replies();
      end
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      write_regs(9'd256, 9'd256);
   endtask

   initial begin
      foreach (shadow_keys[i]) shadow_keys[i] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed_inserts();
      test_register_corners();
      test_random_fill();
      wait_for_replies();
      if (!failed && owed_replies.size() == 0) begin
         $display("[linear_probe_hash_insert] OK");
      end else begin
         $display("[linear_probe_hash_insert] ERROR");
      end
      $finish;
   end

endmodule
